[design/dds_header_mip_layout_macros.svh]
// Assertion macros for the DDS header parser top level.
`ifndef DDS_HEADER_MIP_LAYOUT_MACROS_SVH
`define DDS_HEADER_MIP_LAYOUT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DHML_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define DHML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ddshml_pkg.sv]
// Types, codes and helpers for the DDS header parser and mip layout block.
`default_nettype none
package ddshml_pkg;

	localparam int MAX_LEVELS_DEF = 32;
	localparam int RESULT_CAP     = 32;

	localparam logic [31:0] MAGIC_DDS   = 32'h2053_4444;
	localparam logic [31:0] CC_DX10     = 32'h3031_5844;
	localparam logic [31:0] CC_DXT1     = 32'h3154_5844;
	localparam logic [31:0] CC_DXT3     = 32'h3354_5844;
	localparam logic [31:0] CC_DXT5     = 32'h3554_5844;
	localparam int          FOURCC_BIT  = 2;
	localparam logic [31:0] HDR_SIZE    = 32'd124;
	localparam logic [31:0] PF_SIZE     = 32'd32;
	localparam logic [7:0]  BASE_END    = 8'd128;
	localparam logic [7:0]  DX10_END    = 8'd148;
	localparam logic [31:0] DIM_UNKNOWN = 32'd0;
	localparam logic [31:0] DIM_TEX2D   = 32'd3;
	localparam logic [31:0] DXGI_BC1_LO = 32'd70;
	localparam logic [31:0] DXGI_BC1_HI = 32'd72;
	localparam logic [31:0] DXGI_BC2_LO = 32'd73;
	localparam logic [31:0] DXGI_BC2_HI = 32'd75;
	localparam logic [31:0] DXGI_BC3_LO = 32'd76;
	localparam logic [31:0] DXGI_BC3_HI = 32'd78;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MAGIC     = 3'd1,
		ST_SIZES     = 3'd2,
		ST_DIMENSION = 3'd3,
		ST_ARRAY     = 3'd4,
		ST_FORMAT    = 3'd5,
		ST_OVERFLOW  = 3'd6,
		ST_LEVELS    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		FMT_DXT1 = 2'd0,
		FMT_DXT3 = 2'd1,
		FMT_DXT5 = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_LEVEL
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic check;
		logic step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hdr_err;
		logic lvl_last;
	} sts_t;

	// 4x4 block count along one dimension; zero stays zero
	function automatic logic [14:0] blk_count(input logic [15:0] d);
		logic [16:0] s;
		s = {1'b0, d} + 17'd3;
		return s[16:2];
	endfunction

endpackage
`default_nettype wire

[design/ddshml_ctrl.sv]
// Sequencing controller: accept, header check, one mip level per cycle.
`default_nettype none
module ddshml_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ddshml_pkg::sts_t sts,
	output ddshml_pkg::cmd_t    cmd,
	output logic                busy
);
	import ddshml_pkg::*;

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nx = S_CHECK;
			end
			S_CHECK: begin
				state_nx = sts.hdr_err ? S_IDLE : S_LEVEL;
			end
			S_LEVEL: begin
				if (sts.lvl_last) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_CHECK: cmd.check = 1'b1;
			S_LEVEL: cmd.step  = 1'b1;
			default: busy = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

[design/ddshml_dp.sv]
// Datapath: header word checks, level size multiplier, offset and result registers.
`default_nettype none
module ddshml_dp #(
	parameter int MAX_LEVELS = ddshml_pkg::MAX_LEVELS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ddshml_pkg::cmd_t cmd,
	output ddshml_pkg::sts_t    sts,
	input  wire logic [31:0]    file_magic,
	input  wire logic [31:0]    header_size,
	input  wire logic [31:0]    pixfmt_size,
	input  wire logic [31:0]    pixfmt_flags,
	input  wire logic [31:0]    four_cc,
	input  wire logic [31:0]    dimension,
	input  wire logic [31:0]    array_count,
	input  wire logic [31:0]    dxgi_code,
	input  wire logic [15:0]    base_width,
	input  wire logic [15:0]    base_height,
	input  wire logic [15:0]    level_count,
	input  wire logic [31:0]    file_bytes,
	output logic                strobe,
	output logic [2:0]          status,
	output logic [1:0]          block_format,
	output logic [4:0]          level_index,
	output logic [15:0]         level_width,
	output logic [15:0]         level_height,
	output logic [31:0]         level_offset,
	output logic [31:0]         level_bytes,
	output logic                last
);
	import ddshml_pkg::*;

	localparam int LIMIT = (MAX_LEVELS > RESULT_CAP) ? RESULT_CAP : MAX_LEVELS;

	// captured transaction
	logic [31:0] magic_q, hsize_q, psize_q, flags_q, cc_q, dim_q, arr_q, dxgi_q, fbytes_q;
	logic [15:0] bw_q, bh_q, lvl_q;

	// level walk
	fmt_t        fmt_q;
	logic [31:0] off_q, rem_q;
	logic [15:0] w_q, h_q;
	logic [4:0]  idx_q, last_idx_q;
	logic [29:0] prod_q;

	// result registers
	logic        strobe_q;
	status_t     status_q;
	fmt_t        ofmt_q;
	logic [4:0]  oidx_q;
	logic [15:0] ow_q, oh_q;
	logic [31:0] ooff_q, obytes_q;
	logic        olast_q;

	// header check
	status_t     hdr_sts;
	fmt_t        hdr_fmt;
	logic [7:0]  hdr_off;
	logic        dx10;
	logic [15:0] lvl_eff;

	always_comb begin
		hdr_sts = ST_OK;
		hdr_fmt = FMT_DXT1;
		hdr_off = BASE_END;
		dx10    = flags_q[FOURCC_BIT] && (cc_q == CC_DX10);
		lvl_eff = (lvl_q == 16'd0) ? 16'd1 : lvl_q;
		if (fbytes_q < 32'(BASE_END) || magic_q != MAGIC_DDS) begin
			hdr_sts = ST_MAGIC;
		end else if (hsize_q != HDR_SIZE || psize_q != PF_SIZE) begin
			hdr_sts = ST_SIZES;
		end else if (dx10) begin
			hdr_off = DX10_END;
			if (fbytes_q < 32'(DX10_END)) begin
				hdr_sts = ST_MAGIC;
			end else if (dim_q != DIM_TEX2D && dim_q != DIM_UNKNOWN) begin
				hdr_sts = ST_DIMENSION;
			end else if (arr_q > 32'd1) begin
				hdr_sts = ST_ARRAY;
			end else if (dxgi_q >= DXGI_BC1_LO && dxgi_q <= DXGI_BC1_HI) begin
				hdr_fmt = FMT_DXT1;
			end else if (dxgi_q >= DXGI_BC2_LO && dxgi_q <= DXGI_BC2_HI) begin
				hdr_fmt = FMT_DXT3;
			end else if (dxgi_q >= DXGI_BC3_LO && dxgi_q <= DXGI_BC3_HI) begin
				hdr_fmt = FMT_DXT5;
			end else begin
				hdr_sts = ST_FORMAT;
			end
		end else if (!flags_q[FOURCC_BIT]) begin
			hdr_sts = ST_FORMAT;
		end else if (cc_q == CC_DXT1) begin
			hdr_fmt = FMT_DXT1;
		end else if (cc_q == CC_DXT3) begin
			hdr_fmt = FMT_DXT3;
		end else if (cc_q == CC_DXT5) begin
			hdr_fmt = FMT_DXT5;
		end else begin
			hdr_sts = ST_FORMAT;
		end
		if (hdr_sts == ST_OK && lvl_eff > 16'(LIMIT)) hdr_sts = ST_LEVELS;
	end

	// current level size and fit test
	logic [33:0] size;
	logic        lvl_bad;
	logic [31:0] sat;
	logic [15:0] nw, nh;

	always_comb begin
		size    = (fmt_q == FMT_DXT1) ? {1'b0, prod_q, 3'b000} : {prod_q, 4'b0000};
		lvl_bad = (size == 34'd0) || (size > {2'b00, rem_q});
		sat     = (size[33:32] != 2'b00) ? 32'hFFFF_FFFF : size[31:0];
		nw      = (w_q[15:1] == 15'd0) ? 16'd1 : {1'b0, w_q[15:1]};
		nh      = (h_q[15:1] == 15'd0) ? 16'd1 : {1'b0, h_q[15:1]};
	end

	// shared block-count multiplier: base level on check, next level on step
	logic [14:0] mul_a, mul_b;
	assign mul_a = cmd.check ? blk_count(bw_q) : blk_count(nw);
	assign mul_b = cmd.check ? blk_count(bh_q) : blk_count(nh);

	assign sts.hdr_err  = (hdr_sts != ST_OK);
	assign sts.lvl_last = lvl_bad || (idx_q == last_idx_q);

	// capture and level walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			magic_q  <= file_magic;
			hsize_q  <= header_size;
			psize_q  <= pixfmt_size;
			flags_q  <= pixfmt_flags;
			cc_q     <= four_cc;
			dim_q    <= dimension;
			arr_q    <= array_count;
			dxgi_q   <= dxgi_code;
			bw_q     <= base_width;
			bh_q     <= base_height;
			lvl_q    <= level_count;
			fbytes_q <= file_bytes;
		end
		if (cmd.check) begin
			fmt_q      <= hdr_fmt;
			off_q      <= 32'(hdr_off);
			rem_q      <= fbytes_q - 32'(hdr_off);
			w_q        <= bw_q;
			h_q        <= bh_q;
			idx_q      <= 5'd0;
			last_idx_q <= 5'(lvl_eff - 16'd1);
			prod_q     <= mul_a * mul_b;
		end else if (cmd.step) begin
			off_q  <= off_q + size[31:0];
			rem_q  <= rem_q - size[31:0];
			w_q    <= nw;
			h_q    <= nh;
			idx_q  <= idx_q + 5'd1;
			prod_q <= mul_a * mul_b;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.check && sts.hdr_err) begin
			status_q <= hdr_sts;
			ofmt_q   <= FMT_DXT1;
			oidx_q   <= 5'd0;
			ow_q     <= 16'd0;
			oh_q     <= 16'd0;
			ooff_q   <= 32'd0;
			obytes_q <= 32'd0;
			olast_q  <= 1'b1;
		end else if (cmd.step) begin
			status_q <= lvl_bad ? ST_OVERFLOW : ST_OK;
			ofmt_q   <= fmt_q;
			oidx_q   <= idx_q;
			ow_q     <= w_q;
			oh_q     <= h_q;
			ooff_q   <= off_q;
			obytes_q <= sat;
			olast_q  <= sts.lvl_last;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.check && sts.hdr_err) || cmd.step;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign block_format = ofmt_q;
	assign level_index  = oidx_q;
	assign level_width  = ow_q;
	assign level_height = oh_q;
	assign level_offset = ooff_q;
	assign level_bytes  = obytes_q;
	assign last         = olast_q;

endmodule
`default_nettype wire

[design/dds_header_mip_layout.sv]
// Top level of the DDS texture header parser and mip level layout block.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  header   | start, busy         | file_magic .. file_bytes (12 fields)
//  result   | strobe (one cycle)  | status, block_format, level_index, level_width,
//           |                     | level_height, level_offset, level_bytes, last
//
// A transaction is taken when start is high and busy is low. In the next cycle the
// header words are checked; a header error gives its single result the cycle after.
// Otherwise one mip level result follows per cycle; the shared block-count multiplier
// sets the one-level-per-cycle pace. Results cannot be stalled. Reset clears the
// controller and the strobe only.
`default_nettype none
`include "dds_header_mip_layout_macros.svh"
module dds_header_mip_layout #(
	parameter int MAX_LEVELS = ddshml_pkg::MAX_LEVELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] file_magic,
	input  wire logic [31:0] header_size,
	input  wire logic [31:0] pixfmt_size,
	input  wire logic [31:0] pixfmt_flags,
	input  wire logic [31:0] four_cc,
	input  wire logic [31:0] dimension,
	input  wire logic [31:0] array_count,
	input  wire logic [31:0] dxgi_code,
	input  wire logic [15:0] base_width,
	input  wire logic [15:0] base_height,
	input  wire logic [15:0] level_count,
	input  wire logic [31:0] file_bytes,
	output logic             strobe,
	output logic [2:0]       status,
	output logic [1:0]       block_format,
	output logic [4:0]       level_index,
	output logic [15:0]      level_width,
	output logic [15:0]      level_height,
	output logic [31:0]      level_offset,
	output logic [31:0]      level_bytes,
	output logic             last
);
	import ddshml_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ddshml_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ddshml_dp #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.file_magic   (file_magic),
		.header_size  (header_size),
		.pixfmt_size  (pixfmt_size),
		.pixfmt_flags (pixfmt_flags),
		.four_cc      (four_cc),
		.dimension    (dimension),
		.array_count  (array_count),
		.dxgi_code    (dxgi_code),
		.base_width   (base_width),
		.base_height  (base_height),
		.level_count  (level_count),
		.file_bytes   (file_bytes),
		.strobe       (strobe),
		.status       (status),
		.block_format (block_format),
		.level_index  (level_index),
		.level_width  (level_width),
		.level_height (level_height),
		.level_offset (level_offset),
		.level_bytes  (level_bytes),
		.last         (last)
	);

	// checks
	`DHML_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
	`DHML_ASSERT_SAME(a_idle_after_last, $fell(busy), strobe && last, "busy dropped without last")
	`DHML_ASSERT_NEXT(a_levels_back_to_back, strobe && !last, strobe, "gap in level results")
	`DHML_ASSERT_SAME(a_error_ends_run, strobe && (status != ST_OK), last, "error result not last")

endmodule
`default_nettype wire
